[hw/rtl/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared widths, constants and helper functions for the Euler-to-quaternion
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package e2q_pkg;

  // CORDIC datapath width (Q.30 cosine/sine with headroom)
  localparam int unsigned CW = 34;
  // Half-angle width (Q.29 radians)
  localparam int unsigned ZW = 32;
  // Product widths
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned SW = PW + 1;

  localparam int unsigned ATAN_STEPS = 24;

  localparam logic signed [ZW-1:0] HALF_PI_Q29     = 32'sd843314857;
  localparam logic signed [CW-1:0] CORDIC_START_Q30 = 34'sd652032874;
  localparam logic signed [15:0]   Q14_ONE          = 16'sd16384;

  typedef logic signed [ZW-1:0] atan_tab_t [ATAN_STEPS];

  localparam atan_tab_t ATAN_Q29 = '{
    32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
    32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
    32'sd2097141,   32'sd1048575,   32'sd524288,    32'sd262144,
    32'sd131072,    32'sd65536,     32'sd32768,     32'sd16384,
    32'sd8192,      32'sd4096,      32'sd2048,      32'sd1024,
    32'sd512,       32'sd256,       32'sd128,       32'sd64
  };

  // Round a Q.60 sum to Q.14 and clamp to [-1, 1]
  function automatic logic signed [15:0] sat_q14(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    r = (s + (SW'(1) <<< 45)) >>> 46;
    if (r > SW'(Q14_ONE)) begin
      return Q14_ONE;
    end else if (r < -SW'(Q14_ONE)) begin
      return -Q14_ONE;
    end else begin
      return r[15:0];
    end
  endfunction

endpackage

`default_nettype wire

[hw/rtl/e2q_cordic.sv]
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation-mode CORDIC: cosine and sine of half an input angle,
// one rotation step per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_cordic #(
  parameter int unsigned ANGLE_FRAC_BITS = 13,
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  wire                              clk_i,
  input  wire                              en_i,
  input  wire  logic signed [15:0]         angle_i,
  output logic signed [e2q_pkg::CW-1:0]    cos_o,
  output logic signed [e2q_pkg::CW-1:0]    sin_o
);
  import e2q_pkg::*;

  localparam int unsigned NSTEP = (TRIG_ITERATIONS < ATAN_STEPS) ?
                                  TRIG_ITERATIONS : ATAN_STEPS;
  localparam int unsigned SH    = 28 - ANGLE_FRAC_BITS;
  // wide enough for the scaled angle and for the clamp bound
  localparam int unsigned AW    = ((16 + SH > ZW) ? 16 + SH : ZW) + 1;

  logic signed [AW-1:0] half_ext;
  logic signed [ZW-1:0] half_sat;

  logic signed [CW-1:0] x_q [NSTEP+1];
  logic signed [CW-1:0] y_q [NSTEP+1];
  logic signed [ZW-1:0] z_q [NSTEP+1];

  // Scale to Q.29 half angle and clamp to +-pi/2
  always_comb begin
    half_ext = AW'(angle_i) <<< SH;
    if (half_ext > AW'(HALF_PI_Q29)) begin
      half_sat = HALF_PI_Q29;
    end else if (half_ext < -AW'(HALF_PI_Q29)) begin
      half_sat = -HALF_PI_Q29;
    end else begin
      half_sat = half_ext[ZW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CORDIC_START_Q30;
      y_q[0] <= '0;
      z_q[0] <= half_sat;
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[k][ZW-1]) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - ATAN_Q29[k];
        end else begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + ATAN_Q29[k];
        end
      end
    end
  end

  assign cos_o = x_q[NSTEP];
  assign sin_o = y_q[NSTEP];

endmodule

`default_nettype wire

[hw/rtl/e2q_quat.sv]
// ----------------------------------------------------------------------------
// e2q_quat
// Five-stage product tree: forms w, x, y, z from the half-angle cosines and
// sines, rounds to Q1.14 and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module e2q_quat (
  input  wire                           clk_i,
  input  wire                           en_i,
  input  wire  logic signed [e2q_pkg::CW-1:0] cr_i,
  input  wire  logic signed [e2q_pkg::CW-1:0] sr_i,
  input  wire  logic signed [e2q_pkg::CW-1:0] cp_i,
  input  wire  logic signed [e2q_pkg::CW-1:0] sp_i,
  input  wire  logic signed [e2q_pkg::CW-1:0] cy_i,
  input  wire  logic signed [e2q_pkg::CW-1:0] sy_i,
  output logic signed [15:0]            w_o,
  output logic signed [15:0]            x_o,
  output logic signed [15:0]            y_o,
  output logic signed [15:0]            z_o
);
  import e2q_pkg::*;

  localparam logic signed [PW-1:0] RND30 = PW'(1) <<< 29;

  // stage 1: roll x pitch products
  logic signed [PW-1:0] pcc_q, pss_q, psc_q, pcs_q;
  logic signed [CW-1:0] cy1_q, sy1_q;
  // stage 2: rounded to Q.30
  logic signed [CW-1:0] rcc_q, rss_q, rsc_q, rcs_q;
  logic signed [CW-1:0] cy2_q, sy2_q;
  // stage 3: Q.60 terms
  logic signed [PW-1:0] t_q [8];
  // stage 4: sums
  logic signed [SW-1:0] sw_q, sx_q, sy_q, sz_q;
  // stage 5: outputs
  logic signed [15:0] w_q, x_q, y_q, z_q;

  logic signed [PW-1:0] pcc_r, pss_r, psc_r, pcs_r;

  always_comb begin
    pcc_r = (pcc_q + RND30) >>> 30;
    pss_r = (pss_q + RND30) >>> 30;
    psc_r = (psc_q + RND30) >>> 30;
    pcs_r = (pcs_q + RND30) >>> 30;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pcc_q <= cr_i * cp_i;
      pss_q <= sr_i * sp_i;
      psc_q <= sr_i * cp_i;
      pcs_q <= cr_i * sp_i;
      cy1_q <= cy_i;
      sy1_q <= sy_i;

      rcc_q <= pcc_r[CW-1:0];
      rss_q <= pss_r[CW-1:0];
      rsc_q <= psc_r[CW-1:0];
      rcs_q <= pcs_r[CW-1:0];
      cy2_q <= cy1_q;
      sy2_q <= sy1_q;

      t_q[0] <= rcc_q * cy2_q;
      t_q[1] <= rss_q * sy2_q;
      t_q[2] <= rsc_q * cy2_q;
      t_q[3] <= rcs_q * sy2_q;
      t_q[4] <= rcs_q * cy2_q;
      t_q[5] <= rsc_q * sy2_q;
      t_q[6] <= rcc_q * sy2_q;
      t_q[7] <= rss_q * cy2_q;

      sw_q <= SW'(t_q[0]) + SW'(t_q[1]);
      sx_q <= SW'(t_q[2]) - SW'(t_q[3]);
      sy_q <= SW'(t_q[4]) + SW'(t_q[5]);
      sz_q <= SW'(t_q[6]) - SW'(t_q[7]);

      w_q <= sat_q14(sw_q);
      x_q <= sat_q14(sx_q);
      y_q <= sat_q14(sy_q);
      z_q <= sat_q14(sz_q);
    end
  end

  assign w_o = w_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

[hw/rtl/euler_to_quaternion.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles (Q2.13 radians) to unit quaternion (Q1.14, saturated).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: valid_i, stall_o and roll/pitch/yaw angle ports. A request
//   is taken at a rising edge with valid_i high and stall_o low.
//   Output channel: valid_o, stall_i and quat_w/x/y/z ports; a result is
//   taken at a rising edge with valid_o high and stall_i low.
//   The CORDIC step chain makes up most of the pipeline: one register stage
//   per rotation step (TRIG_ITERATIONS, 16 by default, capped at ATAN_STEPS),
//   plus one for angle scaling and five for the product tree.
//   Throughput: one request per cycle while the output is not stalled.
//   Reset clears all valid bits; no request is in flight afterwards.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   stall_o rises until the result is taken; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_quaternion #(
  parameter int unsigned ANGLE_FRAC_BITS = 13,
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 valid_i,
  output logic                stall_o,
  input  wire  logic signed [15:0] roll_angle_i,
  input  wire  logic signed [15:0] pitch_angle_i,
  input  wire  logic signed [15:0] yaw_angle_i,
  output logic                valid_o,
  input  wire                 stall_i,
  output logic signed [15:0]  quat_w_o,
  output logic signed [15:0]  quat_x_o,
  output logic signed [15:0]  quat_y_o,
  output logic signed [15:0]  quat_z_o
);
  import e2q_pkg::*;

  localparam int unsigned NSTEP = (TRIG_ITERATIONS < ATAN_STEPS) ?
                                  TRIG_ITERATIONS : ATAN_STEPS;
  localparam int unsigned LAT   = NSTEP + 6;

  logic [LAT-1:0] vld_q;
  logic           en;

  logic signed [CW-1:0] cr, sr, cp, sp, cy, sy;

  // advance unless a finished result is held by the receiver
  assign en      = !(vld_q[LAT-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  e2q_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_roll (
    .clk_i(clk_i), .en_i(en), .angle_i(roll_angle_i), .cos_o(cr), .sin_o(sr)
  );

  e2q_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_pitch (
    .clk_i(clk_i), .en_i(en), .angle_i(pitch_angle_i), .cos_o(cp), .sin_o(sp)
  );

  e2q_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_yaw (
    .clk_i(clk_i), .en_i(en), .angle_i(yaw_angle_i), .cos_o(cy), .sin_o(sy)
  );

  e2q_quat u_quat (
    .clk_i(clk_i),
    .en_i (en),
    .cr_i (cr),
    .sr_i (sr),
    .cp_i (cp),
    .sp_i (sp),
    .cy_i (cy),
    .sy_i (sy),
    .w_o  (quat_w_o),
    .x_o  (quat_x_o),
    .y_o  (quat_y_o),
    .z_o  (quat_z_o)
  );

endmodule

`default_nettype wire

[verif/quat_checker.sv]
// ----------------------------------------------------------------------------
// quat_checker
// Watches both channels of the Euler-to-quaternion block, computes the
// expected quaternion for every accepted request and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quat_checker #(
  parameter int unsigned ANGLE_FRAC_BITS = 13,
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               valid_i,
  input  wire               stall_o,
  input  wire signed [15:0] roll_angle_i,
  input  wire signed [15:0] pitch_angle_i,
  input  wire signed [15:0] yaw_angle_i,
  input  wire               valid_o,
  input  wire               stall_i,
  input  wire signed [15:0] quat_w_o,
  input  wire signed [15:0] quat_x_o,
  input  wire signed [15:0] quat_y_o,
  input  wire signed [15:0] quat_z_o,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);
  import e2q_pkg::*;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  quat_t expected_quats[$];

  // CORDIC rotation for cosine and sine of half the angle, in Q.30
  task automatic half_angle_trig(input logic signed [15:0] ang,
                                 output longint c, output longint s);
    longint zq, xq, yq, dx, dy;
    int     steps;
    zq = longint'(ang) <<< (28 - ANGLE_FRAC_BITS);
    xq = 652032874;
    yq = 0;
    steps = (TRIG_ITERATIONS < ATAN_STEPS) ? TRIG_ITERATIONS : ATAN_STEPS;
    if (zq > 843314857) zq = 843314857;
    if (zq < -843314857) zq = -843314857;
    for (int i = 0; i < steps; i++) begin
      dx = yq >>> i;
      dy = xq >>> i;
      if (zq >= 0) begin
        xq -= dx; yq += dy; zq -= longint'(ATAN_Q29[i]);
      end else begin
        xq += dx; yq -= dy; zq += longint'(ATAN_Q29[i]);
      end
    end
    c = xq;
    s = yq;
  endtask

  function automatic longint triple_prod(longint a, longint b, longint c);
    longint ab;
    ab = (a * b + (longint'(1) <<< 29)) >>> 30;
    return ab * c;
  endfunction

  function automatic logic signed [15:0] round_q14(longint q60);
    longint v;
    v = (q60 + (longint'(1) <<< 45)) >>> 46;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  task automatic predict_quat(input logic signed [15:0] r, p, yw, output quat_t q);
    longint cr, sr, cp, sp, cy, sy;
    half_angle_trig(r, cr, sr);
    half_angle_trig(p, cp, sp);
    half_angle_trig(yw, cy, sy);
    q.w = round_q14(triple_prod(cr, cp, cy) + triple_prod(sr, sp, sy));
    q.x = round_q14(triple_prod(sr, cp, cy) - triple_prod(cr, sp, sy));
    q.y = round_q14(triple_prod(cr, sp, cy) + triple_prod(sr, cp, sy));
    q.z = round_q14(triple_prod(cr, cp, sy) - triple_prod(sr, sp, cy));
  endtask

  initial begin
    fail_count_o = 0;
    checked_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin
    quat_t q, got;
    if (rst_ni && valid_i && !stall_o) begin
      predict_quat(roll_angle_i, pitch_angle_i, yaw_angle_i, q);
      expected_quats.push_back(q);
    end
    if (rst_ni && valid_o && !stall_i) begin
      got = '{quat_w_o, quat_x_o, quat_y_o, quat_z_o};
      if (expected_quats.size() == 0) begin
        fail_count_o++;
        if (fail_count_o <= 10) $display("unexpected result %h", got);
      end else begin
        q = expected_quats.pop_front();
        checked_o++;
        if (q != got) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("quat mismatch: exp w=%0d x=%0d y=%0d z=%0d got w=%0d x=%0d y=%0d z=%0d",
                     q.w, q.x, q.y, q.z, got.w, got.x, got.y, got.z);
        end
      end
    end
    pending_o = expected_quats.size();
  end

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives angle triples into the Euler-to-quaternion block with random gaps
// and output stalls; the checker compares every quaternion it returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  logic clk_i, rst_ni, valid_i, stall_i;
  logic signed [15:0] roll_angle_i, pitch_angle_i, yaw_angle_i;
  logic stall_o, valid_o;
  logic signed [15:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  int fail_count, pending, checked;
  bit long_hold, random_stall_on;

  euler_to_quaternion dut (.*);

  quat_checker checker_i (.*, .fail_count_o(fail_count), .pending_o(pending),
                          .checked_o(checked));

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stalls per result, plus one long hold-off
  initial begin
    int wait_cycles;
    stall_i = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        stall_i <= 1;
        repeat (60) @(negedge clk_i);
        long_hold = 0;
        stall_i <= 0;
      end else if (random_stall_on && valid_o && !stall_i) begin
        wait_cycles = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) wait_cycles = 0;
        if (wait_cycles > 0) begin
          stall_i <= 1;
          repeat (wait_cycles) @(negedge clk_i);
          stall_i <= 0;
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 65535));
      1: return $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
      default: return 16'($signed($urandom_range(0, 51472)) - 25736);
    endcase
  endfunction

  task automatic send_request(input logic signed [15:0] r, p, yw, input int gap);
    if (gap > 0) begin
      valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i <= 1;
    roll_angle_i <= r;
    pitch_angle_i <= p;
    yaw_angle_i <= yw;
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    logic signed [15:0] corner [8];
    int timer;
    corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767,
               16'sh8000, 16'sd12868, -16'sd12868, 16'sd1};
    valid_i = 0;
    roll_angle_i = 0;
    pitch_angle_i = 0;
    yaw_angle_i = 0;
    rst_ni = 0;
    random_stall_on = 0;
    long_hold = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: extremes, out-of-range angles, quarter turns
    for (int i = 0; i < 8; i++) send_request(corner[i], corner[(i+3)%8], corner[(i+5)%8], 0);
    for (int i = 0; i < 8; i++) send_request(corner[i], corner[i], corner[i], 0);
    send_request(16'sd25736, 0, 0, 0);
    send_request(0, 16'sd25736, 0, 0);
    send_request(0, 0, -16'sd25736, 0);
    drain_results();

    random_stall_on = 1;
    // back-to-back burst against a long receiver hold
    long_hold = 1;
    for (int i = 0; i < 60; i++) send_request(rand_angle(), rand_angle(), rand_angle(), 0);
    drain_results();

    for (int i = 0; i < 1400; i++) begin
      if (i % 300 < 40) random_stall_on = 0;
      else random_stall_on = 1;
      send_request(rand_angle(), rand_angle(), rand_angle(),
                   (i % 300 < 40) ? 0 : $urandom_range(0, 12));
    end
    drain_results();
    timer = 0;
    while (timer < 40) begin
      @(negedge clk_i);
      timer++;
    end

    $display("Checked %0d quaternions from random and corner angle triples,", checked);
    $display("with input gaps, output stalls and a long output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/e2q_pkg.sv
hw/rtl/e2q_cordic.sv
hw/rtl/e2q_quat.sv
hw/rtl/euler_to_quaternion.sv
verif/quat_checker.sv
verif/testbench.sv
